>>> hw/rtl/fips_pkg.sv
// Shared types, constants and lookup tables for the inverse Park / SVPWM timing block.
// Used by every cell module and by the top level; no dependencies.
`timescale 1ns / 1ps

package fips_pkg;

	// Fixed-point set-up
	localparam int DATA_WIDTH  = 16;
	localparam int GUARD       = DATA_WIDTH - 8;
	localparam int STAGES      = 16;
	localparam int RW          = DATA_WIDTH + GUARD + 3;
	localparam int VW          = 17 + GUARD + 3;
	localparam int ZW          = 33;
	localparam int PW          = 56;
	localparam int UNSCALE_SH  = 28 + GUARD;
	localparam int DIV_STAGES  = 16;
	localparam int REM_W       = 31;

	localparam logic signed [28:0] INVK_Q28  = 29'sd163008219;
	localparam logic signed [26:0] SQRT3_Q24 = 27'sd29058990;
	localparam logic signed [19:0] AMAX      = 20'sd46341;
	localparam logic signed [PW:0] UNSCALE_RND = (PW+1)'(1) <<< (UNSCALE_SH - 1);

	// Configuration register indexes
	localparam logic REG_PWM_PERIOD = 1'b0;
	localparam logic REG_DC_BUS     = 1'b1;

	// Compare candidates
	typedef enum logic [1:0] {
		CAND_U = 2'd0,
		CAND_V = 2'd1,
		CAND_W = 2'd2,
		CAND_G = 2'd3
	} fips_cand_t;

	typedef struct packed {
		fips_cand_t c0;
		fips_cand_t c1;
		fips_cand_t c2;
	} fips_route_t;

	typedef struct packed {
		logic signed [2:0] ta_a;
		logic signed [2:0] ta_b;
		logic signed [2:0] tb_a;
		logic signed [2:0] tb_b;
	} fips_coef_t;

	// Data carried alongside the arithmetic through the later cells
	typedef struct packed {
		logic signed [16:0] al;
		logic signed [16:0] be;
		logic               zero;
		logic [15:0]        mag;
		logic [2:0]         sector;
		logic               sat_a;
		logic               sat_b;
	} fips_side_t;

	// Arctangent of 2^-i in units of 2^-32 turn
	function automatic logic [31:0] fips_atan(input logic [4:0] idx);
		logic [31:0] r;
		case (idx)
			5'd0:  r = 32'h20000000;
			5'd1:  r = 32'h12E4051E;
			5'd2:  r = 32'h09FB385B;
			5'd3:  r = 32'h051111D4;
			5'd4:  r = 32'h028B0D43;
			5'd5:  r = 32'h0145D7E1;
			5'd6:  r = 32'h00A2F61E;
			5'd7:  r = 32'h00517C55;
			5'd8:  r = 32'h0028BE53;
			5'd9:  r = 32'h00145F2F;
			5'd10: r = 32'h000A2F98;
			5'd11: r = 32'h000517CC;
			5'd12: r = 32'h00028BE6;
			5'd13: r = 32'h000145F3;
			5'd14: r = 32'h0000A2FA;
			5'd15: r = 32'h0000517D;
			5'd16: r = 32'h000028BE;
			5'd17: r = 32'h0000145F;
			5'd18: r = 32'h00000A30;
			5'd19: r = 32'h00000518;
			5'd20: r = 32'h0000028C;
			5'd21: r = 32'h00000146;
			5'd22: r = 32'h000000A3;
			5'd23: r = 32'h00000051;
			default: r = 32'h0;
		endcase
		return r;
	endfunction

	// Dwell coefficients per sector (index is sector minus one)
	function automatic fips_coef_t fips_coef(input logic [2:0] k);
		fips_coef_t c;
		case (k)
			3'd0: c = '{3'sd1,  -3'sd1, 3'sd0,  3'sd2};
			3'd1: c = '{3'sd1,  3'sd1,  -3'sd1, 3'sd1};
			3'd2: c = '{3'sd0,  3'sd2,  -3'sd1, -3'sd1};
			3'd3: c = '{-3'sd1, 3'sd1,  3'sd0,  -3'sd2};
			3'd4: c = '{-3'sd1, -3'sd1, 3'sd1,  -3'sd1};
			3'd5: c = '{3'sd0,  -3'sd2, 3'sd1,  3'sd1};
			default: c = '{3'sd1, -3'sd1, 3'sd0, 3'sd2};
		endcase
		return c;
	endfunction

	// Phase routing per sector (index is sector minus one)
	function automatic fips_route_t fips_route(input logic [2:0] k);
		fips_route_t r;
		case (k)
			3'd0: r = '{CAND_U, CAND_V, CAND_W};
			3'd1: r = '{CAND_G, CAND_U, CAND_W};
			3'd2: r = '{CAND_W, CAND_U, CAND_V};
			3'd3: r = '{CAND_W, CAND_G, CAND_U};
			3'd4: r = '{CAND_V, CAND_W, CAND_U};
			3'd5: r = '{CAND_U, CAND_W, CAND_G};
			default: r = '{CAND_U, CAND_V, CAND_W};
		endcase
		return r;
	endfunction

endpackage

>>> hw/rtl/fips_rot_cell.sv
// One rotation-mode CORDIC micro-rotation cell with its pipeline register.
// Depends on fips_pkg.
`timescale 1ns / 1ps

module fips_rot_cell (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             en,
	input  logic [4:0]                       idx,
	input  logic                             in_valid,
	input  logic signed [fips_pkg::RW-1:0]   in_x,
	input  logic signed [fips_pkg::RW-1:0]   in_y,
	input  logic signed [fips_pkg::ZW-1:0]   in_z,
	output logic                             out_valid,
	output logic signed [fips_pkg::RW-1:0]   out_x,
	output logic signed [fips_pkg::RW-1:0]   out_y,
	output logic signed [fips_pkg::ZW-1:0]   out_z
);

	logic signed [fips_pkg::RW-1:0] sx;
	logic signed [fips_pkg::RW-1:0] sy;
	logic signed [fips_pkg::ZW-1:0] ang;
	logic                           valid_s1;
	logic signed [fips_pkg::RW-1:0] x_s1;
	logic signed [fips_pkg::RW-1:0] y_s1;
	logic signed [fips_pkg::ZW-1:0] z_s1;

	// Shifted operands and step angle
	always_comb begin
		sx  = in_x >>> idx;
		sy  = in_y >>> idx;
		ang = fips_pkg::ZW'(fips_pkg::fips_atan(idx));
	end

	// Hold valid under reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
		end
	end

	// Rotate towards zero residual angle
	always_ff @(posedge clk) begin
		if (en) begin
			if (in_z >= 0) begin
				x_s1 <= in_x - sy;
				y_s1 <= in_y + sx;
				z_s1 <= in_z - ang;
			end else begin
				x_s1 <= in_x + sy;
				y_s1 <= in_y - sx;
				z_s1 <= in_z + ang;
			end
		end
	end

	assign out_valid = valid_s1;
	assign out_x     = x_s1;
	assign out_y     = y_s1;
	assign out_z     = z_s1;

endmodule

>>> hw/rtl/fips_vec_cell.sv
// One vectoring-mode CORDIC cell with its pipeline register and side data.
// Depends on fips_pkg.
`timescale 1ns / 1ps

module fips_vec_cell (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             en,
	input  logic [4:0]                       idx,
	input  logic                             in_valid,
	input  logic signed [fips_pkg::VW-1:0]   in_x,
	input  logic signed [fips_pkg::VW-1:0]   in_y,
	input  logic [31:0]                      in_z,
	input  fips_pkg::fips_side_t             in_side,
	output logic                             out_valid,
	output logic signed [fips_pkg::VW-1:0]   out_x,
	output logic signed [fips_pkg::VW-1:0]   out_y,
	output logic [31:0]                      out_z,
	output fips_pkg::fips_side_t             out_side
);

	logic signed [fips_pkg::VW-1:0] sx;
	logic signed [fips_pkg::VW-1:0] sy;
	logic [31:0]                    ang;
	logic                           valid_s1;
	logic signed [fips_pkg::VW-1:0] x_s1;
	logic signed [fips_pkg::VW-1:0] y_s1;
	logic [31:0]                    z_s1;
	fips_pkg::fips_side_t           side_s1;

	always_comb begin
		sx  = in_x >>> idx;
		sy  = in_y >>> idx;
		ang = fips_pkg::fips_atan(idx);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
		end
	end

	// Drive y towards zero, accumulate the angle modulo one turn
	always_ff @(posedge clk) begin
		if (en) begin
			side_s1 <= in_side;
			if (in_y > 0) begin
				x_s1 <= in_x + sy;
				y_s1 <= in_y - sx;
				z_s1 <= in_z + ang;
			end else begin
				x_s1 <= in_x - sy;
				y_s1 <= in_y + sx;
				z_s1 <= in_z - ang;
			end
		end
	end

	assign out_valid = valid_s1;
	assign out_x     = x_s1;
	assign out_y     = y_s1;
	assign out_z     = z_s1;
	assign out_side  = side_s1;

endmodule

>>> hw/rtl/fips_div_cell.sv
// One restoring-division cell: settles one quotient bit of both dwell lanes.
// Depends on fips_pkg.
`timescale 1ns / 1ps

module fips_div_cell (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              en,
	input  logic [3:0]                        idx,
	input  logic [14:0]                       divisor,
	input  logic                              in_valid,
	input  logic [fips_pkg::REM_W-1:0]        in_rem_a,
	input  logic [fips_pkg::REM_W-1:0]        in_rem_b,
	input  logic [15:0]                       in_q_a,
	input  logic [15:0]                       in_q_b,
	input  fips_pkg::fips_side_t              in_side,
	output logic                              out_valid,
	output logic [fips_pkg::REM_W-1:0]        out_rem_a,
	output logic [fips_pkg::REM_W-1:0]        out_rem_b,
	output logic [15:0]                       out_q_a,
	output logic [15:0]                       out_q_b,
	output fips_pkg::fips_side_t              out_side
);

	logic [fips_pkg::REM_W-1:0] trial;
	logic [15:0]                qbit;
	logic                       valid_s1;
	logic [fips_pkg::REM_W-1:0] rem_a_s1;
	logic [fips_pkg::REM_W-1:0] rem_b_s1;
	logic [15:0]                q_a_s1;
	logic [15:0]                q_b_s1;
	fips_pkg::fips_side_t       side_s1;

	always_comb begin
		trial = fips_pkg::REM_W'(divisor) << idx;
		qbit  = 16'd1 << idx;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
		end
	end

	// Subtract the shifted divisor where it fits
	always_ff @(posedge clk) begin
		if (en) begin
			side_s1 <= in_side;
			if (in_rem_a >= trial) begin
				rem_a_s1 <= in_rem_a - trial;
				q_a_s1   <= in_q_a | qbit;
			end else begin
				rem_a_s1 <= in_rem_a;
				q_a_s1   <= in_q_a;
			end
			if (in_rem_b >= trial) begin
				rem_b_s1 <= in_rem_b - trial;
				q_b_s1   <= in_q_b | qbit;
			end else begin
				rem_b_s1 <= in_rem_b;
				q_b_s1   <= in_q_b;
			end
		end
	end

	assign out_valid = valid_s1;
	assign out_rem_a = rem_a_s1;
	assign out_rem_b = rem_b_s1;
	assign out_q_a   = q_a_s1;
	assign out_q_b   = q_b_s1;
	assign out_side  = side_s1;

endmodule

>>> hw/rtl/foc_inverse_park_svpwm_times.sv
// Top level of the inverse Park / space-vector PWM timing block.
// Depends on fips_pkg, fips_rot_cell, fips_vec_cell and fips_div_cell.
//
// Usage:
//   Input items (volt_d, volt_q, rotor_angle) enter on the s_axis group; one result
//   item per input leaves on the m_axis group, in order. pwm_period and
//   dc_bus_voltage are set through cfg_we / cfg_index / cfg_data while idle.
//   Throughput: one item per cycle while no result is stalled at the output, set by
//   the three rows of cells (16 rotation CORDIC cells, 16 vectoring CORDIC cells, 16
//   division cells, one quotient bit each) that each hand their item on every cycle
//   that the pipeline advances.
//   The whole pipeline advances together whenever the output register is empty or
//   is being taken; while the receiver holds m_axis_tready low with a result
//   waiting, the pipeline freezes and s_axis_tready drops, so nothing is lost.
//   Reset clears every valid flag and loads pwm_period = 10000 and
//   dc_bus_voltage = 16384; no clearing pass is needed.
//   A bus voltage of zero is taken as one.
`timescale 1ns / 1ps

module foc_inverse_park_svpwm_times (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// [15:0] volt_d, [31:16] volt_q, [47:32] rotor_angle
	input  logic [47:0]  s_axis_tdata,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// [16:0] volt_alpha, [33:17] volt_beta, [49:34] volt_magnitude, [52:50] sector,
	// [68:53] dwell_first, [84:69] dwell_second, [100:85] dwell_zero,
	// [116:101] compare_phase_a, [132:117] compare_phase_b,
	// [148:133] compare_phase_c, [149] overmodulation, [151:150] zero
	output logic [151:0] m_axis_tdata,
	input  logic         cfg_we,
	input  logic         cfg_index,
	input  logic [15:0]  cfg_data
);

	localparam int RW = fips_pkg::RW;
	localparam int VW = fips_pkg::VW;
	localparam int ZW = fips_pkg::ZW;
	localparam int PW = fips_pkg::PW;
	localparam int NS = fips_pkg::STAGES;
	localparam int ND = fips_pkg::DIV_STAGES;

	logic        en;
	logic [15:0] period_q;
	logic [14:0] vdc_q;
	logic [14:0] vdc;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q <= 16'd10000;
			vdc_q    <= 15'd16384;
		end else if (cfg_we) begin
			case (cfg_index)
				fips_pkg::REG_PWM_PERIOD: period_q <= cfg_data;
				fips_pkg::REG_DC_BUS:     vdc_q    <= cfg_data[14:0];
				default:                  period_q <= period_q;
			endcase
		end
	end

	assign vdc = (vdc_q == 15'd0) ? 15'd1 : vdc_q;

	// Advance the whole pipeline unless a finished item is stalled
	assign en            = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = en;

	// ---------------- Stage 1: quadrant fold ----------------
	logic signed [15:0] in_d;
	logic signed [15:0] in_q;
	logic signed [16:0] ang;
	logic signed [16:0] ang_f;
	logic               flip;
	logic signed [RW-1:0] x0;
	logic signed [RW-1:0] y0;

	always_comb begin
		in_d  = s_axis_tdata[15:0];
		in_q  = s_axis_tdata[31:16];
		ang   = 17'(signed'(s_axis_tdata[47:32]));
		flip  = 1'b0;
		ang_f = ang;
		if (ang > 17'sd16384) begin
			flip  = 1'b1;
			ang_f = ang - 17'sd32768;
		end else if (ang < -17'sd16384) begin
			flip  = 1'b1;
			ang_f = ang + 17'sd32768;
		end
		x0 = RW'(in_d) <<< fips_pkg::GUARD;
		y0 = RW'(in_q) <<< fips_pkg::GUARD;
	end

	logic                 v_s1;
	logic signed [RW-1:0] x_s1;
	logic signed [RW-1:0] y_s1;
	logic signed [ZW-1:0] z_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s1 <= flip ? -x0 : x0;
			y_s1 <= flip ? -y0 : y0;
			z_s1 <= ZW'(ang_f) <<< 16;
		end
	end

	// ---------------- Rotation CORDIC row ----------------
	logic                 rot_v [0:NS];
	logic signed [RW-1:0] rot_x [0:NS];
	logic signed [RW-1:0] rot_y [0:NS];
	logic signed [ZW-1:0] rot_z [0:NS];

	assign rot_v[0] = v_s1;
	assign rot_x[0] = x_s1;
	assign rot_y[0] = y_s1;
	assign rot_z[0] = z_s1;

	for (genvar i = 0; i < NS; i++) begin : g_rot
		fips_rot_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en),
			.idx       (5'(i)),
			.in_valid  (rot_v[i]),
			.in_x      (rot_x[i]),
			.in_y      (rot_y[i]),
			.in_z      (rot_z[i]),
			.out_valid (rot_v[i+1]),
			.out_x     (rot_x[i+1]),
			.out_y     (rot_y[i+1]),
			.out_z     (rot_z[i+1])
		);
	end

	// ---------------- Stages 2-3: gain compensation, clamp ----------------
	logic                 v_s2;
	logic signed [PW-1:0] px_s2;
	logic signed [PW-1:0] py_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= rot_v[NS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			px_s2 <= PW'(rot_x[NS]) * PW'(fips_pkg::INVK_Q28);
			py_s2 <= PW'(rot_y[NS]) * PW'(fips_pkg::INVK_Q28);
		end
	end

	logic signed [PW:0]  rx;
	logic signed [PW:0]  ry;
	logic signed [19:0]  ux;
	logic signed [19:0]  uy;
	logic signed [16:0]  al_c;
	logic signed [16:0]  be_c;

	always_comb begin
		rx = ((PW+1)'(px_s2) + fips_pkg::UNSCALE_RND) >>> fips_pkg::UNSCALE_SH;
		ry = ((PW+1)'(py_s2) + fips_pkg::UNSCALE_RND) >>> fips_pkg::UNSCALE_SH;
		ux = rx[19:0];
		uy = ry[19:0];
		if (ux > fips_pkg::AMAX)       al_c = 17'(fips_pkg::AMAX);
		else if (ux < -fips_pkg::AMAX) al_c = 17'(-fips_pkg::AMAX);
		else                           al_c = ux[16:0];
		if (uy > fips_pkg::AMAX)       be_c = 17'(fips_pkg::AMAX);
		else if (uy < -fips_pkg::AMAX) be_c = 17'(-fips_pkg::AMAX);
		else                           be_c = uy[16:0];
	end

	logic               v_s3;
	logic signed [16:0] al_s3;
	logic signed [16:0] be_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			al_s3 <= al_c;
			be_s3 <= be_c;
		end
	end

	// ---------------- Vectoring CORDIC row ----------------
	logic                 vec_v    [0:NS];
	logic signed [VW-1:0] vec_x    [0:NS];
	logic signed [VW-1:0] vec_y    [0:NS];
	logic [31:0]          vec_z    [0:NS];
	fips_pkg::fips_side_t vec_side [0:NS];
	logic signed [VW-1:0] vx0;
	logic signed [VW-1:0] vy0;

	// Fold the left half-plane onto the right one
	always_comb begin
		vx0 = VW'(al_s3) <<< fips_pkg::GUARD;
		vy0 = VW'(be_s3) <<< fips_pkg::GUARD;
		vec_side[0]        = '0;
		vec_side[0].al     = al_s3;
		vec_side[0].be     = be_s3;
		vec_side[0].zero   = (al_s3 == 17'sd0) && (be_s3 == 17'sd0);
		if (al_s3 < 17'sd0) begin
			vec_x[0] = -vx0;
			vec_y[0] = -vy0;
			vec_z[0] = 32'h8000_0000;
		end else begin
			vec_x[0] = vx0;
			vec_y[0] = vy0;
			vec_z[0] = 32'h0;
		end
	end

	assign vec_v[0] = v_s3;

	for (genvar i = 0; i < NS; i++) begin : g_vec
		fips_vec_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en),
			.idx       (5'(i)),
			.in_valid  (vec_v[i]),
			.in_x      (vec_x[i]),
			.in_y      (vec_y[i]),
			.in_z      (vec_z[i]),
			.in_side   (vec_side[i]),
			.out_valid (vec_v[i+1]),
			.out_x     (vec_x[i+1]),
			.out_y     (vec_y[i+1]),
			.out_z     (vec_z[i+1]),
			.out_side  (vec_side[i+1])
		);
	end

	// ---------------- Stages 4-5: magnitude, sector ----------------
	logic                 v_s4;
	logic signed [PW-1:0] pm_s4;
	logic [31:0]          theta_s4;
	fips_pkg::fips_side_t side_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s4 <= vec_v[NS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pm_s4    <= PW'(vec_x[NS]) * PW'(fips_pkg::INVK_Q28);
			theta_s4 <= vec_side[NS].zero ? 32'h0 : vec_z[NS];
			side_s4  <= vec_side[NS];
		end
	end

	logic signed [PW:0]  rm;
	logic signed [19:0]  um;
	logic [15:0]         mag_c;
	logic [34:0]         theta6;
	fips_pkg::fips_side_t side5_d;

	always_comb begin
		rm = ((PW+1)'(pm_s4) + fips_pkg::UNSCALE_RND) >>> fips_pkg::UNSCALE_SH;
		um = rm[19:0];
		if (side_s4.zero || um < 20'sd0) mag_c = 16'd0;
		else if (um > fips_pkg::AMAX)    mag_c = 16'(fips_pkg::AMAX);
		else                             mag_c = um[15:0];
		theta6         = 35'(theta_s4) * 35'd6;
		side5_d        = side_s4;
		side5_d.mag    = mag_c;
		side5_d.sector = theta6[34:32] + 3'd1;
	end

	logic                 v_s5;
	fips_pkg::fips_side_t side_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s5 <= side5_d;
		end
	end

	// ---------------- Stages 6-9: dwell numerators and scaling ----------------
	fips_pkg::fips_coef_t coef;
	logic signed [20:0]   na_a;
	logic signed [20:0]   na_b;
	logic signed [20:0]   cb_a;
	logic signed [20:0]   cb_b;

	always_comb begin
		coef = fips_pkg::fips_coef(side_s5.sector - 3'd1);
		na_a = 21'(coef.ta_a) * 21'(side_s5.al) * 21'sd3;
		na_b = 21'(coef.tb_a) * 21'(side_s5.al) * 21'sd3;
		cb_a = 21'(coef.ta_b) * 21'(side_s5.be);
		cb_b = 21'(coef.tb_b) * 21'(side_s5.be);
	end

	logic                 v_s6;
	logic signed [20:0]   na_a_s6;
	logic signed [20:0]   na_b_s6;
	logic signed [46:0]   nb_a_s6;
	logic signed [46:0]   nb_b_s6;
	fips_pkg::fips_side_t side_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			na_a_s6 <= na_a;
			na_b_s6 <= na_b;
			nb_a_s6 <= 47'(cb_a) * 47'(fips_pkg::SQRT3_Q24);
			nb_b_s6 <= 47'(cb_b) * 47'(fips_pkg::SQRT3_Q24);
			side_s6 <= side_s5;
		end
	end

	logic signed [46:0] num_a;
	logic signed [46:0] num_b;

	always_comb begin
		num_a = (47'(na_a_s6) <<< 24) + nb_a_s6;
		num_b = (47'(na_b_s6) <<< 24) + nb_b_s6;
	end

	logic                 v_s7;
	logic [43:0]          num_a_s7;
	logic [43:0]          num_b_s7;
	fips_pkg::fips_side_t side_s7;

	// Drop non-positive numerators to zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s7 <= 1'b0;
		end else if (en) begin
			v_s7 <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			num_a_s7 <= (num_a > 47'sd0) ? num_a[43:0] : 44'd0;
			num_b_s7 <= (num_b > 47'sd0) ? num_b[43:0] : 44'd0;
			side_s7  <= side_s6;
		end
	end

	logic                 v_s8;
	logic [59:0]          prod_a_s8;
	logic [59:0]          prod_b_s8;
	fips_pkg::fips_side_t side_s8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s8 <= 1'b0;
		end else if (en) begin
			v_s8 <= v_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_a_s8 <= 60'(num_a_s7) * 60'(period_q);
			prod_b_s8 <= 60'(num_b_s7) * 60'(period_q);
			side_s8   <= side_s7;
		end
	end

	// Round and drop the 2^25 scale, flag quotients beyond 16 bits
	logic [60:0] m_a;
	logic [60:0] m_b;
	logic [35:0] d_a;
	logic [35:0] d_b;
	logic [35:0] lim;
	logic        sat_a;
	logic        sat_b;
	fips_pkg::fips_side_t side9_d;

	always_comb begin
		m_a   = 61'(prod_a_s8) + (61'(vdc) << 24);
		m_b   = 61'(prod_b_s8) + (61'(vdc) << 24);
		d_a   = m_a[60:25];
		d_b   = m_b[60:25];
		lim   = 36'(vdc) << 16;
		sat_a = d_a >= lim;
		sat_b = d_b >= lim;
		side9_d       = side_s8;
		side9_d.sat_a = sat_a;
		side9_d.sat_b = sat_b;
	end

	logic                           v_s9;
	logic [fips_pkg::REM_W-1:0]     rem_a_s9;
	logic [fips_pkg::REM_W-1:0]     rem_b_s9;
	fips_pkg::fips_side_t           side_s9;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s9 <= 1'b0;
		end else if (en) begin
			v_s9 <= v_s8;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_a_s9 <= sat_a ? '0 : d_a[fips_pkg::REM_W-1:0];
			rem_b_s9 <= sat_b ? '0 : d_b[fips_pkg::REM_W-1:0];
			side_s9  <= side9_d;
		end
	end

	// ---------------- Division row ----------------
	logic                       div_v    [0:ND];
	logic [fips_pkg::REM_W-1:0] div_ra   [0:ND];
	logic [fips_pkg::REM_W-1:0] div_rb   [0:ND];
	logic [15:0]                div_qa   [0:ND];
	logic [15:0]                div_qb   [0:ND];
	fips_pkg::fips_side_t       div_side [0:ND];

	assign div_v[0]    = v_s9;
	assign div_ra[0]   = rem_a_s9;
	assign div_rb[0]   = rem_b_s9;
	assign div_qa[0]   = 16'd0;
	assign div_qb[0]   = 16'd0;
	assign div_side[0] = side_s9;

	for (genvar j = 0; j < ND; j++) begin : g_div
		fips_div_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en),
			.idx       (4'(ND - 1 - j)),
			.divisor   (vdc),
			.in_valid  (div_v[j]),
			.in_rem_a  (div_ra[j]),
			.in_rem_b  (div_rb[j]),
			.in_q_a    (div_qa[j]),
			.in_q_b    (div_qb[j]),
			.in_side   (div_side[j]),
			.out_valid (div_v[j+1]),
			.out_rem_a (div_ra[j+1]),
			.out_rem_b (div_rb[j+1]),
			.out_q_a   (div_qa[j+1]),
			.out_q_b   (div_qb[j+1]),
			.out_side  (div_side[j+1])
		);
	end

	// ---------------- Stage 10: dwell times ----------------
	logic [15:0] ta;
	logic [15:0] tb;

	always_comb begin
		ta = div_side[ND].sat_a ? 16'hFFFF : div_qa[ND];
		tb = div_side[ND].sat_b ? 16'hFFFF : div_qb[ND];
	end

	logic                 v_s10;
	logic [15:0]          ta_s10;
	logic [15:0]          tb_s10;
	logic signed [17:0]   t0_s10;
	fips_pkg::fips_side_t side_s10;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s10 <= 1'b0;
		end else if (en) begin
			v_s10 <= div_v[ND];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ta_s10   <= ta;
			tb_s10   <= tb;
			t0_s10   <= signed'(18'(period_q)) - signed'(18'(ta)) - signed'(18'(tb));
			side_s10 <= div_side[ND];
		end
	end

	// ---------------- Output stage: candidates, clamp, routing ----------------
	logic signed [18:0] cand_raw [0:3];
	logic [15:0]        cand     [0:3];
	logic [3:0]         clipped;
	logic signed [18:0] per19;
	fips_pkg::fips_route_t route;
	logic [151:0]       tdata_d;

	always_comb begin
		per19       = signed'(19'(period_q));
		cand_raw[0] = per19 - signed'(19'(ta_s10[15:1]));
		cand_raw[1] = signed'(19'(tb_s10[15:1])) + 19'(t0_s10);
		cand_raw[2] = signed'(19'(tb_s10[15:1]));
		cand_raw[3] = signed'(19'(tb_s10[15:1])) + signed'(19'(ta_s10));
		for (int c = 0; c < 4; c++) begin
			if (cand_raw[c] < 19'sd0) begin
				cand[c]    = 16'd0;
				clipped[c] = 1'b1;
			end else if (cand_raw[c] > per19) begin
				cand[c]    = period_q;
				clipped[c] = 1'b1;
			end else begin
				cand[c]    = cand_raw[c][15:0];
				clipped[c] = 1'b0;
			end
		end
		route = fips_pkg::fips_route(side_s10.sector - 3'd1);
		tdata_d             = '0;
		tdata_d[16:0]       = side_s10.al;
		tdata_d[33:17]      = side_s10.be;
		tdata_d[49:34]      = side_s10.mag;
		tdata_d[52:50]      = side_s10.sector;
		tdata_d[68:53]      = ta_s10;
		tdata_d[84:69]      = tb_s10;
		tdata_d[100:85]     = (t0_s10 < 18'sd0) ? 16'd0 : t0_s10[15:0];
		tdata_d[116:101]    = cand[route.c0];
		tdata_d[132:117]    = cand[route.c1];
		tdata_d[148:133]    = cand[route.c2];
		tdata_d[149]        = (t0_s10 < 18'sd0) || (clipped != 4'd0);
	end

	logic         out_valid_q;
	logic [151:0] out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= v_s10;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_data_q <= tdata_d;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

endmodule

>>> hw/rtl/fips_checker.sv
// Port-level checks for the inverse Park / SVPWM timing block, bound to its top level.
// Depends only on the top level's ports.
`timescale 1ns / 1ps

module fips_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         s_axis_tready,
	input logic         m_axis_tvalid,
	input logic         m_axis_tready,
	input logic [151:0] m_axis_tdata
);

	// A stalled result keeps its valid and its data
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result item changed while stalled");

	// Input is refused only while a result is stalled
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
		else $error("input refused without output stall");

	// Sector is always one to six
	a_sector: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[52:50] != 3'd0 && m_axis_tdata[52:50] != 3'd7)
		else $error("sector out of range");

	// Reset empties the output
	a_reset: assert property (@(posedge clk)
		!arst_n |-> !m_axis_tvalid)
		else $error("output valid during reset");

endmodule

bind foc_inverse_park_svpwm_times fips_checker u_fips_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);
